// ===== sv/vdd_pkg.sv =====
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared constants and codes for the vertex dent/decay pipeline.
// ----------------------------------------------------------------------------
package vdd_pkg;

    // pipelined unit depths
    localparam int SQRT_LAT = 32;   // one result bit per stage, 64-bit radicand
    localparam int DIV_LAT  = 44;   // one quotient bit per stage
    localparam int TEN_LAT  = 3;    // reciprocal divide by ten

    // restoring divider geometry
    localparam int DIV_NUM_W = 76;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_QUO_W = DIV_LAT;

    // end to end latency: 4 front stages, sqrt, falloff divide, 2 multiplies,
    // divide by ten, 2 product stages, push divide, output register
    localparam int LAT = 4 + SQRT_LAT + DIV_LAT + 2 + TEN_LAT + 2 + DIV_LAT + 1;

    localparam logic [16:0] ONE_Q16        = 17'h10000;
    localparam logic [63:0] NEAR_ORIGIN_SQ = 64'd43;
    localparam logic [3:0]  MAG_DIVISOR    = 4'd10;
    // ceil(2^31 / 10): exact floor(y / 10) as (y * RECIP_TEN) >> 31 for y < 2^27
    localparam logic [27:0] RECIP_TEN      = 28'd214748365;

    typedef enum logic [2:0] {
        CFG_CONTACT_X = 3'd0,
        CFG_CONTACT_Y = 3'd1,
        CFG_CONTACT_Z = 3'd2,
        CFG_IMPULSE   = 3'd3,
        CFG_STRENGTH  = 3'd4,
        CFG_DECAY     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        CMD_DAMAGE = 1'b0,
        CMD_DECAY  = 1'b1
    } t_cmd;

endpackage

// ===== sv/vdd_sqrt.sv =====
// ----------------------------------------------------------------------------
// vdd_sqrt
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit radicand.
// ----------------------------------------------------------------------------
module vdd_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [34:0] r_rem  [0:vdd_pkg::SQRT_LAT-1];
    logic [31:0] r_root [0:vdd_pkg::SQRT_LAT-1];
    logic [63:0] r_x    [0:vdd_pkg::SQRT_LAT-1];

    logic [34:0] s_rem  [0:vdd_pkg::SQRT_LAT-1];
    logic [31:0] s_root [0:vdd_pkg::SQRT_LAT-1];
    logic [63:0] s_x    [0:vdd_pkg::SQRT_LAT-1];

    logic [34:0] n_rem  [0:vdd_pkg::SQRT_LAT-1];
    logic [31:0] n_root [0:vdd_pkg::SQRT_LAT-1];
    logic [63:0] n_x    [0:vdd_pkg::SQRT_LAT-1];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_x[0]    = i_rad;
        for (int k = 1; k < vdd_pkg::SQRT_LAT; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_x[k]    = r_x[k-1];
        end
    end

    // one radicand bit pair per stage
    always_comb begin
        for (int k = 0; k < vdd_pkg::SQRT_LAT; k++) begin
            logic [34:0] cur;
            logic [34:0] trial;
            cur   = {s_rem[k][32:0], s_x[k][63:62]};
            trial = {1'b0, s_root[k], 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {s_root[k][30:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {s_root[k][30:0], 1'b0};
            end
            n_x[k] = {s_x[k][61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < vdd_pkg::SQRT_LAT; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= n_x[k];
            end
        end
    end

    assign o_root = r_root[vdd_pkg::SQRT_LAT-1];

endmodule

// ===== sv/vdd_div.sv =====
// ----------------------------------------------------------------------------
// vdd_div
// Pipelined restoring divider; quotient must fit DIV_QUO_W bits.
// ----------------------------------------------------------------------------
module vdd_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [vdd_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [vdd_pkg::DIV_DEN_W-1:0]     i_den,
    output logic [vdd_pkg::DIV_QUO_W-1:0]     o_quo
);

    localparam int NW = vdd_pkg::DIV_NUM_W;
    localparam int DW = vdd_pkg::DIV_DEN_W;
    localparam int QW = vdd_pkg::DIV_QUO_W;
    localparam int N  = vdd_pkg::DIV_LAT;

    logic [DW-1:0] r_rem [0:N-1];
    logic [QW-1:0] r_lo  [0:N-1];
    logic [QW-1:0] r_quo [0:N-1];
    logic [DW-1:0] r_den [0:N-1];

    logic [DW-1:0] s_rem [0:N-1];
    logic [QW-1:0] s_lo  [0:N-1];
    logic [QW-1:0] s_quo [0:N-1];
    logic [DW-1:0] s_den [0:N-1];

    logic [DW-1:0] n_rem [0:N-1];
    logic [QW-1:0] n_quo [0:N-1];

    always_comb begin
        s_rem[0] = i_num[NW-1:QW];
        s_lo[0]  = i_num[QW-1:0];
        s_quo[0] = '0;
        s_den[0] = i_den;
        for (int k = 1; k < N; k++) begin
            s_rem[k] = r_rem[k-1];
            s_lo[k]  = r_lo[k-1];
            s_quo[k] = r_quo[k-1];
            s_den[k] = r_den[k-1];
        end
    end

    // shift in next numerator bit, subtract when it fits
    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [DW:0] t;
            t = {s_rem[k], s_lo[k][QW-1]};
            if (t >= {1'b0, s_den[k]}) begin
                n_rem[k] = DW'(t - {1'b0, s_den[k]});
                n_quo[k] = {s_quo[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DW-1:0];
                n_quo[k] = {s_quo[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= {s_lo[k][QW-2:0], 1'b0};
                r_quo[k] <= n_quo[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

// ===== sv/vertex_dent_deform.sv =====
// ----------------------------------------------------------------------------
// vertex_dent_deform
// Per-vertex dent and decay kernel on Q16.16 offsets, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis side carry a rest vertex and its current offset
//   (tdata) and the command (tuser: 0 dent, 1 decay). Every input beat yields
//   exactly one output beat on m_axis, in order: the new offset (tdata) and
//   the touched flag (tuser).
//   Contact point, impulse, strength and decay factor are set through the
//   cfg write port while no beats are in flight.
// Depth and throughput:
//   132 register stages; one beat per cycle sustained while the receiver
//   does not hold the output beat. The depth is set by the 32-stage square
//   root and the two 44-stage bit-per-stage dividers (falloff, push); the
//   divide by ten is a 3-stage reciprocal multiply.
// Reset:
//   synchronous, active low; empties the pipeline and loads register
//   defaults (contact 0, impulse 0, strength 1.0, decay factor 1.0).
// Back-pressure:
//   the whole pipe advances together; when the output beat is held by the
//   receiver, the pipe freezes and s_axis tready drops in the same cycle.
//   Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vertex_dent_deform (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] vertex_x, [63:32] vertex_y, [95:64] vertex_z,
    // [127:96] offset_x, [159:128] offset_y, [191:160] offset_z
    input  logic [191:0] i_s_axis_tdata,
    // [0] command
    input  logic         i_s_axis_tuser,
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] new_offset_x, [63:32] new_offset_y, [95:64] new_offset_z
    output logic [95:0]  o_m_axis_tdata,
    // [0] touched
    output logic         o_m_axis_tuser
);

    localparam int LAT = vdd_pkg::LAT;
    localparam int SQL = vdd_pkg::SQRT_LAT;
    localparam int DVL = vdd_pkg::DIV_LAT;

    // per-item data carried alongside the arithmetic units
    typedef struct packed {
        logic              dent;
        logic              dec;
        logic [2:0][31:0]  o;
        logic [2:0]        vneg;
        logic [2:0][31:0]  a;
        logic [31:0]       len;
        logic [2:0][31:0]  dv;
    } t_side;

    // ---------------- configuration ----------------
    logic signed [31:0] r_contact [3];
    logic [30:0]        r_impulse;
    logic [30:0]        r_strength;
    logic [16:0]        r_decay;
    logic [59:0]        r_rsq;
    logic [29:0]        w_radius;
    logic               w_f_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact[0] <= '0;
            r_contact[1] <= '0;
            r_contact[2] <= '0;
            r_impulse    <= '0;
            r_strength   <= 31'(vdd_pkg::ONE_Q16);
            r_decay      <= vdd_pkg::ONE_Q16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vdd_pkg::CFG_CONTACT_X: r_contact[0] <= i_cfg_data;
                vdd_pkg::CFG_CONTACT_Y: r_contact[1] <= i_cfg_data;
                vdd_pkg::CFG_CONTACT_Z: r_contact[2] <= i_cfg_data;
                vdd_pkg::CFG_IMPULSE:   r_impulse    <= i_cfg_data[30:0];
                vdd_pkg::CFG_STRENGTH:  r_strength   <= i_cfg_data[30:0];
                vdd_pkg::CFG_DECAY:     r_decay      <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign w_radius = r_impulse[30:1];
    assign w_f_lt   = r_decay < vdd_pkg::ONE_Q16;   // above one clamps to one

    always_ff @(posedge i_clk) begin
        r_rsq <= 60'(w_radius) * 60'(w_radius);
    end

    // ---------------- flow control ----------------
    logic r_vld [0:LAT-1];
    logic w_en;
    logic w_acc;

    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_acc;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- stage 1: capture ----------------
    logic               r1_cmd;
    logic signed [31:0] r1_v [3];
    logic [2:0][31:0]   r1_o;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd  <= i_s_axis_tuser;
            r1_v[0] <= i_s_axis_tdata[31:0];
            r1_v[1] <= i_s_axis_tdata[63:32];
            r1_v[2] <= i_s_axis_tdata[95:64];
            r1_o    <= i_s_axis_tdata[191:96];
        end
    end

    // ---------------- stage 2: distances to contact and origin ----------------
    logic [29:0]      r2_d [3];
    logic [2:0][31:0] r2_a;
    logic [2:0]       r2_vneg;
    logic             r2_inside;
    logic             r2_cmd;
    logic [2:0][31:0] r2_o;

    logic [29:0]      w2_d [3];
    logic [2:0][31:0] w2_a;
    logic [2:0]       w2_vneg;
    logic             w2_inside;

    always_comb begin
        w2_inside = w_radius != '0;
        for (int c = 0; c < 3; c++) begin
            logic signed [32:0] diff;
            logic [32:0]        mag;
            diff       = {r1_v[c][31], r1_v[c]} - {r_contact[c][31], r_contact[c]};
            mag        = diff[32] ? 33'(-diff) : 33'(diff);
            w2_d[c]    = mag[29:0];
            if (mag >= {3'b000, w_radius}) w2_inside = 1'b0;
            w2_vneg[c] = r1_v[c][31];
            w2_a[c]    = r1_v[c][31] ? 32'(32'd0 - r1_v[c]) : 32'(r1_v[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d      <= w2_d;
            r2_a      <= w2_a;
            r2_vneg   <= w2_vneg;
            r2_inside <= w2_inside;
            r2_cmd    <= r1_cmd;
            r2_o      <= r1_o;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic [59:0]      r3_dsq [3];
    logic [63:0]      r3_asq [3];
    logic [2:0][31:0] r3_a;
    logic [2:0]       r3_vneg;
    logic             r3_inside;
    logic             r3_cmd;
    logic [2:0][31:0] r3_o;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_dsq[c] <= 60'(r2_d[c]) * 60'(r2_d[c]);
                r3_asq[c] <= 64'(r2_a[c]) * 64'(r2_a[c]);
            end
            r3_a      <= r2_a;
            r3_vneg   <= r2_vneg;
            r3_inside <= r2_inside;
            r3_cmd    <= r2_cmd;
            r3_o      <= r2_o;
        end
    end

    // ---------------- stage 4: sums of squares ----------------
    logic [61:0]      r4_dsq;
    logic [63:0]      r4_vsq;
    logic [2:0][31:0] r4_a;
    logic [2:0]       r4_vneg;
    logic             r4_inside;
    logic             r4_cmd;
    logic [2:0][31:0] r4_o;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_dsq    <= 62'(r3_dsq[0]) + 62'(r3_dsq[1]) + 62'(r3_dsq[2]);
            r4_vsq    <= r3_asq[0] + r3_asq[1] + r3_asq[2];
            r4_a      <= r3_a;
            r4_vneg   <= r3_vneg;
            r4_inside <= r3_inside;
            r4_cmd    <= r3_cmd;
            r4_o      <= r3_o;
        end
    end

    // dent decision: inside the sphere and away from the origin; decay when factor below one
    t_side w4_side;

    always_comb begin
        w4_side      = '0;
        w4_side.dent = (r4_cmd == vdd_pkg::CMD_DAMAGE) && r4_inside
                    && ({2'b00, r4_dsq} < {4'h0, r_rsq})
                    && (r4_vsq >= vdd_pkg::NEAR_ORIGIN_SQ);
        w4_side.dec  = (r4_cmd == vdd_pkg::CMD_DECAY) && w_f_lt;
        w4_side.o    = r4_o;
        w4_side.vneg = r4_vneg;
        w4_side.a    = r4_a;
    end

    // ---------------- square roots: dist and len ----------------
    logic [31:0] w_dist;
    logic [31:0] w_len;
    t_side       r_sq_side [0:SQL-1];

    vdd_sqrt u_sqrt_dist (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  ({2'b00, r4_dsq}),
        .o_root (w_dist)
    );

    vdd_sqrt u_sqrt_len (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_vsq),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= w4_side;
            for (int k = 1; k < SQL; k++) r_sq_side[k] <= r_sq_side[k-1];
        end
    end

    // ---------------- falloff divide: dist * 65536 / radius ----------------
    t_side       w_sq_out;
    logic [43:0] w_q1;
    t_side       r_d1_side [0:DVL-1];

    always_comb begin
        w_sq_out     = r_sq_side[SQL-1];
        w_sq_out.len = w_len;
    end

    vdd_div u_div_fall (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({30'd0, w_dist[29:0], 16'd0}),
        .i_den ({2'b00, w_radius}),
        .o_quo (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_side[0] <= w_sq_out;
            for (int k = 1; k < DVL; k++) r_d1_side[k] <= r_d1_side[k-1];
        end
    end

    // ---------------- magnitude multiplies ----------------
    logic [16:0] w_fall;
    logic [47:0] w_fi;
    logic [30:0] r_m1_p;
    t_side       r_m1_side;
    logic [61:0] r_m2_ps;
    t_side       r_m2_side;

    assign w_fall = vdd_pkg::ONE_Q16 - {1'b0, w_q1[15:0]};
    assign w_fi   = 48'(w_fall) * 48'(r_impulse);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_p    <= w_fi[46:16];
            r_m1_side <= r_d1_side[DVL-1];
            r_m2_ps   <= 62'(r_m1_p) * 62'(r_strength);
            r_m2_side <= r_m1_side;
        end
    end

    // ---------------- divide by ten after the Q16 shift ----------------
    // 46-bit dividend split in 23-bit halves; each half divided by reciprocal
    // multiply, the high remainder carried into the low half.
    logic [50:0] w_t1_prod;
    logic [19:0] r_t1_qh;
    logic [3:0]  r_t1_xh;
    logic [22:0] r_t1_xl;
    t_side       r_t1_side;
    logic [3:0]  w_t2_rh;
    logic [26:0] r_t2_y;
    logic [19:0] r_t2_qh;
    t_side       r_t2_side;
    logic [54:0] w_t3_prod;
    logic [19:0] r_t3_qh;
    logic [22:0] r_t3_ql;
    t_side       r_t3_side;
    logic [43:0] w_m;

    assign w_t1_prod = 51'(r_m2_ps[61:39]) * 51'(vdd_pkg::RECIP_TEN);
    // remainder is below ten, so the low nibbles are enough
    assign w_t2_rh   = r_t1_xh - 4'(r_t1_qh[3:0] * vdd_pkg::MAG_DIVISOR);
    assign w_t3_prod = 55'(r_t2_y) * 55'(vdd_pkg::RECIP_TEN);
    assign w_m       = {1'b0, r_t3_qh, r_t3_ql};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_qh   <= w_t1_prod[50:31];
            r_t1_xh   <= r_m2_ps[42:39];
            r_t1_xl   <= r_m2_ps[38:16];
            r_t1_side <= r_m2_side;
            r_t2_y    <= {w_t2_rh, r_t1_xl};
            r_t2_qh   <= r_t1_qh;
            r_t2_side <= r_t1_side;
            r_t3_qh   <= r_t2_qh;
            r_t3_ql   <= w_t3_prod[53:31];
            r_t3_side <= r_t2_side;
        end
    end

    // ---------------- push products |v_c| * m, decay products ----------------
    logic [53:0] r_p1_lo [3];
    logic [53:0] r_p1_hi [3];
    logic [48:0] r_p1_dp [3];
    t_side       r_p1_side;
    logic [75:0] r_p2_prod [3];
    t_side       r_p2_side;
    t_side       w_p2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                logic [31:0] omag;
                omag = r_t3_side.o[c][31] ? 32'(32'd0 - r_t3_side.o[c])
                                          : r_t3_side.o[c];
                r_p1_lo[c] <= 54'(r_t3_side.a[c]) * 54'(w_m[21:0]);
                r_p1_hi[c] <= 54'(r_t3_side.a[c]) * 54'(w_m[43:22]);
                r_p1_dp[c] <= 49'(omag) * 49'(r_decay);
            end
            r_p1_side <= r_t3_side;
        end
    end

    // decay: round half away from zero on the magnitude
    always_comb begin
        w_p2_side = r_p1_side;
        for (int c = 0; c < 3; c++) begin
            logic [48:0] rnd;
            rnd = r_p1_dp[c] + 49'd32768;
            w_p2_side.dv[c] = r_p1_side.o[c][31] ? 32'(32'd0 - rnd[47:16]) : rnd[47:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_p2_prod[c] <= 76'(r_p1_lo[c]) + (76'(r_p1_hi[c]) << 22);
            end
            r_p2_side <= w_p2_side;
        end
    end

    // ---------------- push divide by len ----------------
    logic [43:0] w_push [3];
    t_side       r_d3_side [0:DVL-1];

    for (genvar c = 0; c < 3; c++) begin : g_push
        vdd_div u_div_push (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p2_prod[c]),
            .i_den (r_p2_side.len),
            .o_quo (w_push[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d3_side[0] <= r_p2_side;
            for (int k = 1; k < DVL; k++) r_d3_side[k] <= r_d3_side[k-1];
        end
    end

    // ---------------- apply and saturate ----------------
    t_side      w_fin;
    logic [95:0] n_out;
    logic [95:0] r_out;
    logic        r_touched;

    assign w_fin = r_d3_side[DVL-1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [45:0] nv;
            logic signed [45:0] ov;
            logic signed [45:0] pv;
            ov = 46'(signed'(w_fin.o[c]));
            pv = signed'({2'b00, w_push[c]});
            nv = w_fin.vneg[c] ? ov + pv : ov - pv;
            if (w_fin.dent) begin
                if (nv > 46'sd2147483647)       n_out[c*32 +: 32] = 32'h7fff_ffff;
                else if (nv < -46'sd2147483648) n_out[c*32 +: 32] = 32'h8000_0000;
                else                            n_out[c*32 +: 32] = nv[31:0];
            end else if (w_fin.dec) begin
                n_out[c*32 +: 32] = w_fin.dv[c];
            end else begin
                n_out[c*32 +: 32] = w_fin.o[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out     <= n_out;
            r_touched <= w_fin.dent || w_fin.dec;
        end
    end

    assign o_m_axis_tdata = r_out;
    assign o_m_axis_tuser = r_touched;

    // ---------------- assertions ----------------
    a_dent_dec_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w4_side.dent && w4_side.dec))
        else $error("dent and decay both set");

    a_dist_in_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3 + SQL] && w_sq_out.dent) |-> (w_dist < {2'b00, w_radius}))
        else $error("dist not below radius on a dent");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT - DVL - 2] && r_p2_side.dent) |-> (r_p2_side.len >= 32'd6))
        else $error("push divisor too small on a dent");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_touched))
        else $error("output changed under stall");

endmodule

// ===== bench/tb_vertex_dent_deform.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_dent_deform
// Self-checking bench for the vertex dent/decay pipeline.
// ----------------------------------------------------------------------------
// A directed table (reset defaults, extremes, near origin, radius edges,
// decay corners) is followed by random phases under several register
// settings and idling mixes. Every output beat is checked field by field
// against a typed-in answer or a bench model of dent and decay arithmetic.
// ----------------------------------------------------------------------------
module tb_vertex_dent_deform;

    typedef struct {
        logic               cmd;
        logic signed [31:0] vtx [3];
        logic signed [31:0] ofs [3];
    } t_vert_in;

    typedef struct {
        logic [31:0] ofs [3];
        logic        touched;
    } t_vert_out;

    // directed row: inputs, plus an optional typed-in answer
    typedef struct {
        t_vert_in  vin;
        bit        has_ans;
        t_vert_out ans;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [191:0] i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [95:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;

    vertex_dent_deform i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // bench copy of the block's registers
    logic signed [31:0] mdl_contact [3];
    logic [30:0]        mdl_impulse;
    logic [30:0]        mdl_strength;
    logic [16:0]        mdl_decay;

    t_vert_out offset_q [$];
    int        n_err = 0;
    int        n_beats = 0;
    int        n_touched = 0;
    int        idle_pct = 0;   // sender gap percentage
    int        stall_pct = 0;  // receiver stall percentage
    string     fld_name [3] = '{"new_offset_x", "new_offset_y", "new_offset_z"};

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // expected new offset for one vertex beat
    function automatic t_vert_out dent_or_decay(t_vert_in x);
        t_vert_out r;
        longint unsigned rad, d [3], a [3], dsq, vsq, dst, falloff, p, m;
        longint unsigned len, q1, r1, push, f, rr;
        bit in_rad;
        for (int i = 0; i < 3; i++) r.ofs[i] = x.ofs[i];
        r.touched = 1'b0;
        if (x.cmd == vdd_pkg::CMD_DAMAGE) begin
            rad = mdl_impulse >> 1;
            in_rad = (rad != 0);
            for (int i = 0; i < 3; i++) begin
                d[i] = absl(longint'(x.vtx[i]) - longint'(mdl_contact[i]));
                if (d[i] >= rad) in_rad = 0;
            end
            if (in_rad) begin
                dsq = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
                vsq = 0;
                for (int i = 0; i < 3; i++) begin
                    a[i] = absl(longint'(x.vtx[i]));
                    vsq += a[i]*a[i];
                end
                if (dsq < rad*rad && vsq >= vdd_pkg::NEAR_ORIGIN_SQ) begin
                    dst     = isqrt(dsq);
                    falloff = 65536 - (dst << 16) / rad;
                    p       = (falloff * mdl_impulse) >> 16;
                    m       = (p * mdl_strength) / (10 * 65536);
                    len     = isqrt(vsq);
                    q1 = m / len;
                    r1 = m % len;
                    for (int i = 0; i < 3; i++) begin
                        push = a[i]*q1 + (a[i]*r1) / len;
                        r.ofs[i] = clamp32(x.vtx[i] < 0 ?
                            longint'(x.ofs[i]) + longint'(push) :
                            longint'(x.ofs[i]) - longint'(push));
                    end
                    r.touched = 1'b1;
                end
            end
        end else begin
            f = (mdl_decay > vdd_pkg::ONE_Q16) ? 65536 : mdl_decay;
            if (f != 65536) begin
                for (int i = 0; i < 3; i++) begin
                    rr = (absl(longint'(x.ofs[i])) * f + 32768) >> 16;
                    r.ofs[i] = clamp32(x.ofs[i] < 0 ? -longint'(rr) : longint'(rr));
                end
                r.touched = 1'b1;
            end
        end
        return r;
    endfunction

    // register write, also mirrored into the bench copy
    task automatic write_reg(vdd_pkg::t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            vdd_pkg::CFG_CONTACT_X: mdl_contact[0] = val;
            vdd_pkg::CFG_CONTACT_Y: mdl_contact[1] = val;
            vdd_pkg::CFG_CONTACT_Z: mdl_contact[2] = val;
            vdd_pkg::CFG_IMPULSE:   mdl_impulse    = val[30:0];
            vdd_pkg::CFG_STRENGTH:  mdl_strength   = val[30:0];
            vdd_pkg::CFG_DECAY:     mdl_decay      = val[16:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] imp, logic [31:0] str, logic [31:0] dec);
        write_reg(vdd_pkg::CFG_CONTACT_X, cx);
        write_reg(vdd_pkg::CFG_CONTACT_Y, cy);
        write_reg(vdd_pkg::CFG_CONTACT_Z, cz);
        write_reg(vdd_pkg::CFG_IMPULSE, imp);
        write_reg(vdd_pkg::CFG_STRENGTH, str);
        write_reg(vdd_pkg::CFG_DECAY, dec);
    endtask

    // one input beat; expected result queued at acceptance
    task automatic send_vertex(t_vert_in x, bit has_ans, t_vert_out ans);
        if ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= x.cmd;
        i_s_axis_tdata  <= {x.ofs[2], x.ofs[1], x.ofs[0],
                            x.vtx[2], x.vtx[1], x.vtx[0]};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        offset_q.push_back(has_ans ? ans : dent_or_decay(x));
    endtask

    // wait for the pipe to drain before touching the registers
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (offset_q.size() != 0) @(posedge i_clk);
        repeat (vdd_pkg::LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_near(logic [31:0] c, int span);
        return c + $urandom_range(2*span) - span;
    endfunction

    // random vertex: mostly near the contact so dents fire, some full range
    function automatic t_vert_in rnd_vertex();
        t_vert_in x;
        int span;
        x.cmd = $urandom_range(1);
        span = (mdl_impulse >> 1) + 1;
        if (span > 32'h3fff_ffff) span = 32'h3fff_ffff;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) < 7) x.vtx[i] = rnd_near(mdl_contact[i], span);
            else x.vtx[i] = $urandom;
            case ($urandom_range(3))
                0: x.ofs[i] = $urandom;
                1: x.ofs[i] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
                default: x.ofs[i] = $urandom_range(2000000) - 1000000;
            endcase
        end
        return x;
    endfunction

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_vert_out e;
            if (offset_q.size() == 0) begin
                $error("output beat with nothing expected");
                n_err++;
            end else begin
                e = offset_q.pop_front();
                n_beats++;
                if (o_m_axis_tuser) n_touched++;
                for (int i = 0; i < 3; i++)
                    if (o_m_axis_tdata[32*i +: 32] !== e.ofs[i]) begin
                        $error("%s exp %h got %h", fld_name[i], e.ofs[i],
                               o_m_axis_tdata[32*i +: 32]);
                        n_err++;
                    end
                if (o_m_axis_tuser !== e.touched) begin
                    $error("touched exp %b got %b", e.touched, o_m_axis_tuser);
                    n_err++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        t_row      rows [$];
        t_row      rw;
        t_vert_out none;
        t_vert_in  x;
        mdl_contact[0] = 0; mdl_contact[1] = 0; mdl_contact[2] = 0;
        mdl_impulse = 0; mdl_strength = 31'd65536; mdl_decay = 17'h10000;
        none.touched = 0;
        for (int i = 0; i < 3; i++) none.ofs[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero impulse, unit decay -> pass through untouched
        for (int k = 0; k < 4; k++) begin
            rw.vin.cmd = k[0];
            for (int i = 0; i < 3; i++) begin
                rw.vin.vtx[i] = k[1] ? 32'h8000_0000 : 32'h7fff_ffff;
                rw.vin.ofs[i] = k[1] ? 32'h7fff_ffff : 32'h8000_0000;
                rw.ans.ofs[i] = rw.vin.ofs[i];
            end
            rw.has_ans = 1; rw.ans.touched = 0;
            rows.push_back(rw);
        end
        foreach (rows[k]) send_vertex(rows[k].vin, rows[k].has_ans, rows[k].ans);
        drain();

        // dent setting: contact (1,1,1), big impulse, strong
        set_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0004_0000, 32'h7fff_ffff, 32'h0000_0000);
        rows.delete();
        // near origin, exactly at origin, on the radius, at contact, extremes
        for (int k = 0; k < 10; k++) begin
            rw.has_ans = 0;
            rw.vin.cmd = (k >= 7);
            for (int i = 0; i < 3; i++) begin
                case (k)
                    0: rw.vin.vtx[i] = (i == 0) ? 32'd3 : 32'd0;
                    1: rw.vin.vtx[i] = 0;
                    2: rw.vin.vtx[i] = (i == 0) ? 32'h0003_0000 : 32'h0001_0000;
                    3: rw.vin.vtx[i] = 32'h0001_0000;
                    4: rw.vin.vtx[i] = 32'hffff_0000;
                    5: rw.vin.vtx[i] = (i == 0) ? 32'd7 : 32'd0;
                    default: rw.vin.vtx[i] = 32'h0000_8000;
                endcase
                rw.vin.ofs[i] = (k == 6) ? 32'h8000_0000 :
                                (k == 8) ? 32'h7fff_ffff : 32'h0000_1234;
            end
            rows.push_back(rw);
        end
        foreach (rows[k]) send_vertex(rows[k].vin, rows[k].has_ans, rows[k].ans);
        drain();
        // decay factor above one saturates to one
        write_reg(vdd_pkg::CFG_DECAY, 32'h0001_ffff);
        x = rows[8].vin;
        rw.ans.touched = 0;
        for (int i = 0; i < 3; i++) rw.ans.ofs[i] = x.ofs[i];
        send_vertex(x, 1, rw.ans);
        drain();

        // random phases, each with its own register setting and idling mix
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            case (ph % 3)
                0: set_all($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(32'h1_ffff));
                1: set_all($urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000),
                           $urandom_range(32'h0010_0000), $urandom_range(32'h0040_0000),
                           $urandom_range(32'h0100_0000), $urandom_range(65536));
                default: set_all(32'h7fff_ffff, 32'h8000_0000, $urandom,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
            endcase
            for (int n = 0; n < 150; n++) send_vertex(rnd_vertex(), 0, none);
            drain();
        end

        $display("tb: %0d beats checked, %0d of them touched, over 12 random settings",
                 n_beats, n_touched);
        if (n_err == 0 && offset_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
sv/vdd_pkg.sv
sv/vdd_sqrt.sv
sv/vdd_div.sv
sv/vertex_dent_deform.sv
bench/tb_vertex_dent_deform.sv
